FILE: hdl/generational_handle_pool_unit_macros.svh
// Assertion macros for the generational handle pool unit.
// Included by the top-level RTL file, which carries the concurrent assertions; no other dependency.
`ifndef GENERATIONAL_HANDLE_POOL_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked assertion, disabled while the active-low reset is asserted.
`define GHP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define GHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/ghp_pkg.sv
// Package for the generational handle pool: field widths, default sizes,
// command and status codes, sequencer state and free stack control type. No dependencies.
`default_nettype none
package ghp_pkg;

	// Default sizes of the pool.
	localparam int DEF_SLOT_COUNT = 256;
	localparam int DEF_GEN_BITS   = 32;
	localparam int DEF_COUNT_BITS = 16;

	// Fixed widths of the word fields.
	localparam int CMD_W = 2;
	localparam int IDX_W = 8;
	localparam int GEN_W = 32;
	localparam int CNT_W = 16;
	localparam int ST_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RETAIN  = 2'd1,
		CMD_LOOKUP  = 2'd2,
		CMD_RELEASE = 2'd3
	} ghp_cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_STALE    = 3'd1,
		ST_FULL     = 3'd2,
		ST_DEAD     = 3'd3,
		ST_OVERFLOW = 3'd4
	} ghp_status_t;

	typedef enum logic {
		GHP_IDLE = 1'b0,
		GHP_EXEC = 1'b1
	} ghp_state_t;

	// Free stack control from the sequencer.
	typedef struct packed {
		logic rd;
		logic push;
		logic pop;
	} ghp_stk_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/ghp_req_if.sv
// Command channel interface: valid/ready handshake with the command word fields.
// Depends on ghp_pkg for the field widths.
`default_nettype none
interface ghp_req_if;
	logic                       valid;
	logic                       ready;
	logic [ghp_pkg::CMD_W-1:0]  command;
	logic [ghp_pkg::IDX_W-1:0]  slot_index;
	logic [ghp_pkg::GEN_W-1:0]  handle_generation;

	modport source (output valid, output command, output slot_index,
		output handle_generation, input ready);
	modport sink (input valid, input command, input slot_index,
		input handle_generation, output ready);
endinterface
`default_nettype wire

FILE: hdl/ghp_rsp_if.sv
// Result channel interface: valid/ready handshake with the result word fields.
// Depends on ghp_pkg for the field widths.
`default_nettype none
interface ghp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ghp_pkg::ST_W-1:0]   status;
	logic [ghp_pkg::IDX_W-1:0]  result_index;
	logic [ghp_pkg::GEN_W-1:0]  result_generation;
	logic [ghp_pkg::CNT_W-1:0]  reference_count;
	logic                       slot_freed;

	modport source (output valid, output status, output result_index,
		output result_generation, output reference_count, output slot_freed,
		input ready);
	modport sink (input valid, input status, input result_index,
		input result_generation, input reference_count, input slot_freed,
		output ready);
endinterface
`default_nettype wire

FILE: hdl/generational_handle_pool_unit.sv
// Top level of the generational handle pool: command sequencer, slot memory and
// result register. Depends on ghp_pkg, ghp_req_if, ghp_rsp_if, ghp_free_stack and the macros header.
//
//  channel  modport  fields
//  req      sink     command, slot_index, handle_generation
//  rsp      source   status, result_index, result_generation, reference_count, slot_freed
//
// A command is taken in idle with the synchronous read of the slot memory
// and of the free stack top, then checked, modified and written back in execute.
// The next command is taken in the cycle after write-back, so no new command is
// taken while one is in flight or its write-back waits on the result register.
// A result held by a stalled rsp delays write-back of the following command.
// Reset clears the sequencer, fill mark, stack depth and result valid; the slot
// memory needs no clearing pass since no slot at or above the fill mark is used.
`default_nettype none
`include "generational_handle_pool_unit_macros.svh"
module generational_handle_pool_unit #(
	parameter int SLOT_COUNT = ghp_pkg::DEF_SLOT_COUNT,
	parameter int GEN_BITS   = ghp_pkg::DEF_GEN_BITS,
	parameter int COUNT_BITS = ghp_pkg::DEF_COUNT_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ghp_req_if.sink   req,
	ghp_rsp_if.source rsp
);
	import ghp_pkg::*;

	localparam int SI_W   = $clog2(SLOT_COUNT);
	localparam int DEP_W  = SI_W + 1;
	localparam int CMP_W  = (DEP_W > IDX_W + 1) ? DEP_W : IDX_W + 1;
	localparam int SLOT_W = GEN_BITS + COUNT_BITS + 1;
	localparam int GX_W   = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;
	localparam int CX_W   = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;

	ghp_state_t state_q, state_nxt;
	logic       req_acc;
	logic       exec_go;

	// Command registers.
	ghp_cmd_t           cmd_q;
	logic [CMP_W-1:0]   idx_q;
	logic [GEN_W-1:0]   hgen_q;
	logic [CMP_W-1:0]   req_idx;

	// Slot memory: {generation, count, live}.
	logic [SLOT_W-1:0]  slot_mem_q [SLOT_COUNT];
	logic [SLOT_W-1:0]  slot_rd_q;
	logic               slot_we;
	logic [SI_W-1:0]    slot_wa;
	logic [SLOT_W-1:0]  slot_wd;

	logic [DEP_W-1:0]   mark_q;
	logic               mark_inc;

	// Free stack connections.
	ghp_stk_ctl_t       stk_ctl;
	logic [SI_W-1:0]    top_slot;
	logic [GEN_BITS-1:0] top_gen;
	logic [DEP_W-1:0]   stk_depth;

	// Decoded read data and results.
	logic [GEN_BITS-1:0]   gen_rd;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  live_rd;
	logic [GX_W-1:0]       gen_rd_x;
	logic [GEN_BITS-1:0]   gen_next;
	logic                  in_range;
	ghp_status_t           res_st;
	logic [CMP_W-1:0]      res_idx;
	logic [GEN_BITS-1:0]   res_gen;
	logic [COUNT_BITS-1:0] res_cnt;
	logic                  res_freed;
	logic [GX_W-1:0]       res_gen_x;
	logic [CX_W-1:0]       res_cnt_x;

	// Result register.
	logic               rsp_valid_q;
	ghp_status_t        rsp_st_q;
	logic [IDX_W-1:0]   rsp_idx_q;
	logic [GEN_W-1:0]   rsp_gen_q;
	logic [CNT_W-1:0]   rsp_cnt_q;
	logic               rsp_freed_q;

	assign req_idx = CMP_W'(req.slot_index);

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			GHP_IDLE: begin
				if (req.valid) begin
					state_nxt = GHP_EXEC;
				end
			end
			GHP_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_nxt = GHP_IDLE;
				end
			end
			default: state_nxt = GHP_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready = 1'b0;
		exec_go   = 1'b0;
		case (state_q)
			GHP_IDLE: req.ready = 1'b1;
			GHP_EXEC: exec_go = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				exec_go   = 1'b0;
			end
		endcase
	end

	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GHP_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the command word.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q  <= ghp_cmd_t'(req.command);
			idx_q  <= req_idx;
			hgen_q <= req.handle_generation;
		end
	end

	// Slot memory read on acceptance and write on write-back.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			slot_rd_q <= slot_mem_q[req_idx[SI_W-1:0]];
		end
		if (slot_we) begin
			slot_mem_q[slot_wa] <= slot_wd;
		end
	end

	assign gen_rd   = slot_rd_q[SLOT_W-1 -: GEN_BITS];
	assign cnt_rd   = slot_rd_q[COUNT_BITS:1];
	assign live_rd  = slot_rd_q[0];
	assign gen_rd_x = GX_W'(gen_rd);
	assign in_range = idx_q < CMP_W'(mark_q);
	// The generation skips zero when it wraps.
	assign gen_next = (GEN_BITS'(gen_rd + GEN_BITS'(1)) == '0) ? GEN_BITS'(1)
		: GEN_BITS'(gen_rd + GEN_BITS'(1));

	// Check and modify for the command held in the execute stage.
	always_comb begin
		res_st    = ST_OK;
		res_idx   = idx_q;
		res_gen   = '0;
		res_cnt   = '0;
		res_freed = 1'b0;
		slot_we   = 1'b0;
		slot_wa   = idx_q[SI_W-1:0];
		slot_wd   = slot_rd_q;
		mark_inc  = 1'b0;
		stk_ctl.rd   = req_acc;
		stk_ctl.push = 1'b0;
		stk_ctl.pop  = 1'b0;
		case (cmd_q)
			CMD_ALLOC: begin
				if (stk_depth != '0) begin
					stk_ctl.pop = exec_go;
					res_idx = CMP_W'(top_slot);
					res_gen = top_gen;
					res_cnt = COUNT_BITS'(1);
					slot_we = exec_go;
					slot_wa = top_slot;
					slot_wd = {top_gen, COUNT_BITS'(1), 1'b1};
				end else if (mark_q < DEP_W'(SLOT_COUNT)) begin
					mark_inc = exec_go;
					res_idx = CMP_W'(mark_q);
					res_gen = GEN_BITS'(1);
					res_cnt = COUNT_BITS'(1);
					slot_we = exec_go;
					slot_wa = mark_q[SI_W-1:0];
					slot_wd = {GEN_BITS'(1), COUNT_BITS'(1), 1'b1};
				end else begin
					res_st  = ST_FULL;
					res_idx = '0;
				end
			end
			CMD_RETAIN: begin
				if (!in_range) begin
					res_st = ST_STALE;
				end else if (!live_rd) begin
					res_st  = ST_DEAD;
					res_gen = gen_rd;
					res_cnt = cnt_rd;
				end else if (cnt_rd == '1) begin
					res_st  = ST_OVERFLOW;
					res_gen = gen_rd;
					res_cnt = cnt_rd;
				end else begin
					res_gen = gen_rd;
					res_cnt = COUNT_BITS'(cnt_rd + COUNT_BITS'(1));
					slot_we = exec_go;
					slot_wd = {gen_rd, COUNT_BITS'(cnt_rd + COUNT_BITS'(1)), 1'b1};
				end
			end
			CMD_LOOKUP, CMD_RELEASE: begin
				if (!in_range || (hgen_q == '0) || (hgen_q != gen_rd_x[GEN_W-1:0])) begin
					res_st = ST_STALE;
				end else if (!live_rd) begin
					res_st  = ST_DEAD;
					res_gen = gen_rd;
					res_cnt = cnt_rd;
				end else if (cmd_q == CMD_LOOKUP) begin
					res_gen = gen_rd;
					res_cnt = cnt_rd;
				end else if (cnt_rd > COUNT_BITS'(1)) begin
					res_gen = gen_rd;
					res_cnt = COUNT_BITS'(cnt_rd - COUNT_BITS'(1));
					slot_we = exec_go;
					slot_wd = {gen_rd, COUNT_BITS'(cnt_rd - COUNT_BITS'(1)), 1'b1};
				end else begin
					// Last reference gone: retire the slot and push it.
					res_gen      = gen_next;
					res_freed    = 1'b1;
					slot_we      = exec_go;
					slot_wd      = {gen_next, COUNT_BITS'(0), 1'b0};
					stk_ctl.push = exec_go;
				end
			end
			default: res_st = ST_STALE;
		endcase
	end

	ghp_free_stack #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS)
	) u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_slot (idx_q[SI_W-1:0]),
		.push_gen  (gen_next),
		.top_slot  (top_slot),
		.top_gen   (top_gen),
		.depth     (stk_depth)
	);

	// Fresh slot fill mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (mark_inc) begin
			mark_q <= DEP_W'(mark_q + DEP_W'(1));
		end
	end

	assign res_gen_x = GX_W'(res_gen);
	assign res_cnt_x = CX_W'(res_cnt);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register word.
	always_ff @(posedge clk) begin
		if (exec_go) begin
			rsp_st_q    <= res_st;
			rsp_idx_q   <= res_idx[IDX_W-1:0];
			rsp_gen_q   <= res_gen_x[GEN_W-1:0];
			rsp_cnt_q   <= res_cnt_x[CNT_W-1:0];
			rsp_freed_q <= res_freed;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_st_q;
	assign rsp.result_index      = rsp_idx_q;
	assign rsp.result_generation = rsp_gen_q;
	assign rsp.reference_count   = rsp_cnt_q;
	assign rsp.slot_freed        = rsp_freed_q;

	// Every freed slot was handed out once, so the stack never outgrows the mark.
	`GHP_ASSERT(a_depth_le_mark, clk, arst_n, stk_depth <= mark_q, "free stack deeper than fill mark")
	// The fill mark only grows.
	`GHP_ASSERT(a_mark_monotonic, clk, arst_n, 1'b1 |=> mark_q >= $past(mark_q), "fill mark went down")
	// A write-back always leaves a result word in the register.
	`GHP_ASSERT(a_exec_gives_result, clk, arst_n, exec_go |=> rsp_valid_q, "write-back without result")
	// A freed slot is only reported on a successful release.
	`GHP_ASSERT(a_freed_ok, clk, arst_n, (rsp_valid_q && rsp_freed_q) |-> (rsp_st_q == ST_OK), "slot freed with error status")

endmodule
`default_nettype wire

FILE: hdl/ghp_free_stack.sv
// Last-in-first-out stack of freed slots, each entry holding the slot number and
// the generation it will be handed out with. Depends on ghp_pkg.
`default_nettype none
module ghp_free_stack #(
	parameter int SLOT_COUNT = ghp_pkg::DEF_SLOT_COUNT,
	parameter int GEN_BITS   = ghp_pkg::DEF_GEN_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ghp_pkg::ghp_stk_ctl_t           ctl,
	input  wire logic [$clog2(SLOT_COUNT)-1:0]   push_slot,
	input  wire logic [GEN_BITS-1:0]             push_gen,
	output logic [$clog2(SLOT_COUNT)-1:0]        top_slot,
	output logic [GEN_BITS-1:0]                  top_gen,
	output logic [$clog2(SLOT_COUNT):0]          depth
);
	import ghp_pkg::*;

	localparam int SI_W  = $clog2(SLOT_COUNT);
	localparam int DEP_W = SI_W + 1;
	localparam int ENT_W = SI_W + GEN_BITS;

	logic [ENT_W-1:0] stk_mem_q [SLOT_COUNT];
	logic [ENT_W-1:0] top_q;
	logic [DEP_W-1:0] depth_q;
	logic [DEP_W-1:0] top_addr;

	// The entry on top sits one below the depth.
	assign top_addr = DEP_W'(depth_q - DEP_W'(1));

	// Synchronous read of the top entry, issued when a command is taken.
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			top_q <= stk_mem_q[top_addr[SI_W-1:0]];
		end
	end

	// Push writes at the current depth.
	always_ff @(posedge clk) begin
		if (ctl.push && (depth_q < DEP_W'(SLOT_COUNT))) begin
			stk_mem_q[depth_q[SI_W-1:0]] <= {push_slot, push_gen};
		end
	end

	// Depth counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.pop && (depth_q != '0)) begin
			depth_q <= DEP_W'(depth_q - DEP_W'(1));
		end else if (ctl.push && (depth_q < DEP_W'(SLOT_COUNT))) begin
			depth_q <= DEP_W'(depth_q + DEP_W'(1));
		end
	end

	assign top_slot = top_q[ENT_W-1 -: SI_W];
	assign top_gen  = top_q[GEN_BITS-1:0];
	assign depth    = depth_q;

endmodule
`default_nettype wire

FILE: dv/tb_generational_handle_pool_unit.sv
// Self-checking testbench for the generational handle pool unit: directed and random
// commands with a built-in predictor of the slot tables. Depends on ghp_pkg, ghp_req_if,
// ghp_rsp_if and generational_handle_pool_unit.
`timescale 1ns / 100ps
module tb_generational_handle_pool_unit;
	import ghp_pkg::*;

	localparam int POOL_SLOTS = 256;
	localparam logic [CNT_W-1:0] REFS_MAX = '1;
	localparam int IDLE_PERCENT = 21;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		ghp_cmd_t           command;
		logic [IDX_W-1:0]   slot_index;
		logic [GEN_W-1:0]   handle_generation;
	} cmd_word_t;

	typedef struct packed {
		ghp_status_t        status;
		logic [IDX_W-1:0]   result_index;
		logic [GEN_W-1:0]   result_generation;
		logic [CNT_W-1:0]   reference_count;
		logic               slot_freed;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;

	ghp_req_if cmd_bus ();
	ghp_rsp_if res_bus ();

	generational_handle_pool_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_bus),
		.rsp    (res_bus)
	);

	// Predicted contents of the pool.
	logic [GEN_W-1:0] slot_gen   [POOL_SLOTS];
	logic [CNT_W-1:0] slot_refs  [POOL_SLOTS];
	bit               slot_live  [POOL_SLOTS];
	logic [IDX_W-1:0] free_slots [POOL_SLOTS];
	int               free_top   = 0;
	int               fresh_mark = 0;

	cmd_word_t    pending_cmds [$];
	result_word_t awaited_results [$];

	bit quiet = 1'b0;
	bit word_taken = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatch_count = 0;

	// Applies one command to the predicted pool and returns the word it should produce.
	function automatic result_word_t pool_step(cmd_word_t w);
		result_word_t r;
		int s;
		int i;
		r = '0;
		r.status = ST_OK;
		i = int'(w.slot_index);
		if (w.command == CMD_ALLOC) begin
			if (free_top > 0) begin
				free_top--;
				s = int'(free_slots[free_top]);
			end else if (fresh_mark < POOL_SLOTS) begin
				s = fresh_mark;
				fresh_mark++;
				slot_gen[s] = GEN_W'(1);
			end else begin
				r.status = ST_FULL;
				return r;
			end
			slot_refs[s] = CNT_W'(1);
			slot_live[s] = 1'b1;
			r.result_index = IDX_W'(s);
			r.result_generation = slot_gen[s];
			r.reference_count = CNT_W'(1);
			return r;
		end
		r.result_index = w.slot_index;
		// A slot at or beyond the fill mark has never been handed out.
		if (i >= fresh_mark) begin
			r.status = ST_STALE;
			return r;
		end
		// Retain disregards the generation carried by the handle.
		if (w.command == CMD_RETAIN) begin
			r.result_generation = slot_gen[i];
			if (!slot_live[i]) begin
				r.status = ST_DEAD;
			end else if (slot_refs[i] == REFS_MAX) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot_refs[i]++;
			end
			r.reference_count = slot_refs[i];
			return r;
		end
		if (w.handle_generation == '0 || w.handle_generation != slot_gen[i]) begin
			r.status = ST_STALE;
			return r;
		end
		if (!slot_live[i] || w.command == CMD_LOOKUP) begin
			if (!slot_live[i])
				r.status = ST_DEAD;
			r.result_generation = slot_gen[i];
			r.reference_count = slot_refs[i];
			return r;
		end
		// Release: the last reference retires the slot and bumps its generation past zero.
		if (slot_refs[i] > CNT_W'(1)) begin
			slot_refs[i]--;
		end else begin
			slot_refs[i] = '0;
			slot_live[i] = 1'b0;
			slot_gen[i] = GEN_W'(slot_gen[i] + GEN_W'(1));
			if (slot_gen[i] == '0)
				slot_gen[i] = GEN_W'(1);
			free_slots[free_top] = w.slot_index;
			free_top++;
			r.slot_freed = 1'b1;
		end
		r.result_generation = slot_gen[i];
		r.reference_count = slot_refs[i];
		return r;
	endfunction

	// Clock.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Driver: record accepted command words and predict their results.
	always @(posedge clk) begin
		cmd_word_t w;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			w.command = ghp_cmd_t'(cmd_bus.command);
			w.slot_index = cmd_bus.slot_index;
			w.handle_generation = cmd_bus.handle_generation;
			awaited_results.insert(awaited_results.size(), pool_step(w));
			void'(pending_cmds.pop_front());
			word_taken = 1'b1;
		end
	end

	// Driver: present the next pending word on the falling edge, idling at random.
	always @(negedge clk) begin
		if (arst_n && (!cmd_bus.valid || word_taken)) begin
			word_taken = 1'b0;
			if (pending_cmds.size() != 0 &&
					(quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
				cmd_bus.valid <= 1'b1;
				cmd_bus.command <= pending_cmds[0].command;
				cmd_bus.slot_index <= pending_cmds[0].slot_index;
				cmd_bus.handle_generation <= pending_cmds[0].handle_generation;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// Monitor: result ready, with random stalls and a long hold-off when the stimulus asks for one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= quiet || $urandom_range(99) >= IDLE_PERCENT;
			end
		end
	end

	// Monitor: compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		result_word_t want;
		result_word_t got;
		bit bad;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.status = ghp_status_t'(res_bus.status);
			got.result_index = res_bus.result_index;
			got.result_generation = res_bus.result_generation;
			got.reference_count = res_bus.reference_count;
			got.slot_freed = res_bus.slot_freed;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result word status=%0d index=%0d", $realtime,
						got.status, got.result_index);
			end else begin
				want = awaited_results.pop_front();
				bad = (got.status !== want.status)
					|| (got.result_index !== want.result_index)
					|| (got.result_generation !== want.result_generation)
					|| (got.reference_count !== want.reference_count)
					|| (got.slot_freed !== want.slot_freed);
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: mismatch expected st=%0d idx=%0d gen=%0h cnt=%0d freed=%0d",
							$realtime, want.status, want.result_index,
							want.result_generation, want.reference_count, want.slot_freed);
						$display("    got st=%0d idx=%0d gen=%0h cnt=%0d freed=%0d",
							got.status, got.result_index, got.result_generation,
							got.reference_count, got.slot_freed);
					end
				end
			end
		end
	end

	// Queue a command word, keeping only a short backlog so choices track the pool.
	task automatic offer(ghp_cmd_t c, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
		cmd_word_t w;
		while (pending_cmds.size() >= 4)
			@(posedge clk);
		w.command = c;
		w.slot_index = idx;
		w.handle_generation = gen;
		pending_cmds.insert(pending_cmds.size(), w);
	endtask

	// Sender pause until every expected word has arrived.
	task automatic drain();
		while (pending_cmds.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Choose a slot that the pool currently believes live, with its generation.
	function automatic bit pick_live(output logic [IDX_W-1:0] idx,
			output logic [GEN_W-1:0] gen);
		int k;
		idx = IDX_W'($urandom_range(POOL_SLOTS - 1));
		gen = GEN_W'(1);
		for (k = 0; k < 32; k++) begin
			idx = IDX_W'($urandom_range(POOL_SLOTS - 1));
			if (idx < fresh_mark && slot_live[idx]) begin
				gen = slot_gen[idx];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Stimulus and end of run.
	initial begin
		int i;
		int need;
		int pick;
		logic [IDX_W-1:0] sel_idx;
		logic [GEN_W-1:0] sel_gen;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_ALLOC;
		cmd_bus.slot_index = '0;
		cmd_bus.handle_generation = '0;
		res_bus.ready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: handles never handed out, null and stale handles, retire and reuse.
		offer(CMD_LOOKUP, 8'd0, 32'd1);
		offer(CMD_RETAIN, 8'd255, 32'd0);
		offer(CMD_RELEASE, 8'd7, 32'hFFFF_FFFF);
		offer(CMD_ALLOC, 8'd0, 32'd0);
		offer(CMD_LOOKUP, 8'd0, 32'd1);
		offer(CMD_LOOKUP, 8'd0, 32'd0);
		offer(CMD_LOOKUP, 8'd0, 32'hFFFF_FFFF);
		offer(CMD_RETAIN, 8'd0, 32'd0);
		offer(CMD_RELEASE, 8'd0, 32'd1);
		offer(CMD_RELEASE, 8'd0, 32'd1);
		offer(CMD_LOOKUP, 8'd0, 32'd1);
		offer(CMD_LOOKUP, 8'd0, 32'd2);
		offer(CMD_RETAIN, 8'd0, 32'hA5A5_A5A5);
		offer(CMD_RELEASE, 8'd0, 32'd2);
		offer(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF);
		offer(CMD_ALLOC, 8'd0, 32'd0);
		offer(CMD_ALLOC, 8'd0, 32'd0);
		offer(CMD_RELEASE, 8'd1, 32'd1);
		offer(CMD_RELEASE, 8'd2, 32'd1);
		offer(CMD_ALLOC, 8'd0, 32'd0);
		offer(CMD_ALLOC, 8'd0, 32'd0);
		offer(CMD_LOOKUP, 8'd1, 32'd2);
		offer(CMD_LOOKUP, 8'd255, 32'd1);
		drain();

		// Fill the pool to the brim and beyond while the result side holds off.
		hold_requests++;
		need = POOL_SLOTS - fresh_mark + free_top + 3;
		for (i = 0; i < need; i++)
			offer(CMD_ALLOC, IDX_W'($urandom), $urandom);

		// Random traffic: mostly well-formed handles, some stale ones and some noise.
		for (i = 0; i < 280; i++) begin
			if (i == 140)
				drain();
			pick = $urandom_range(99);
			if (pick < 25) begin
				offer(CMD_ALLOC, IDX_W'($urandom), $urandom);
			end else if (pick < 72) begin
				void'(pick_live(sel_idx, sel_gen));
				if (pick < 45)
					offer(CMD_RELEASE, sel_idx, sel_gen);
				else if (pick < 58)
					offer(CMD_RETAIN, sel_idx, $urandom);
				else
					offer(CMD_LOOKUP, sel_idx, sel_gen);
			end else if (pick < 82) begin
				void'(pick_live(sel_idx, sel_gen));
				sel_gen = sel_gen ^ (32'd1 << $urandom_range(31));
				offer(pick < 77 ? CMD_LOOKUP : CMD_RELEASE, sel_idx, sel_gen);
			end else begin
				offer(ghp_cmd_t'($urandom_range(3)), IDX_W'($urandom),
					$urandom_range(7) == 0 ? 32'd0 : $urandom);
			end
		end
		drain();

		// A full-rate burst of retains on one slot, then a lookup, a release and a retain.
		quiet = 1'b1;
		if (!pick_live(sel_idx, sel_gen)) begin
			offer(CMD_ALLOC, 8'd0, 32'd0);
			drain();
			void'(pick_live(sel_idx, sel_gen));
		end
		for (i = 0; i < 40; i++)
			offer(CMD_RETAIN, sel_idx, $urandom);
		offer(CMD_LOOKUP, sel_idx, sel_gen);
		offer(CMD_RELEASE, sel_idx, sel_gen);
		offer(CMD_RETAIN, sel_idx, sel_gen);
		drain();
		quiet = 1'b0;

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#(200_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: generational_handle_pool_unit.f
+incdir+hdl
hdl/ghp_pkg.sv
hdl/ghp_req_if.sv
hdl/ghp_rsp_if.sv
hdl/ghp_free_stack.sv
hdl/generational_handle_pool_unit.sv
dv/tb_generational_handle_pool_unit.sv
